// ===== rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram package
// Shared widths, action codes, datapath operations and port structures.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int unsigned BINS    = 1024;
  localparam int unsigned BIN_W   = $clog2(BINS);
  localparam int unsigned SMP_W   = 32;
  localparam int unsigned CNT_W   = 48;
  localparam int unsigned TOT_W   = 64;
  localparam int unsigned SPR_W   = 64;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned FRAC_SH = 16;
  localparam int unsigned SUM_W   = CNT_W + BIN_W + 1;
  localparam int unsigned D_W     = CNT_W + BIN_W;
  localparam int unsigned HALF_W  = CNT_W / 2;
  localparam int unsigned PROD_W  = 2 * CNT_W;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned SBIT_W  = $clog2(SMP_W);

  localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(CNT_W - 1);
  localparam logic [STEP_W-1:0] MUL_FIRST = STEP_W'(4);
  localparam logic [STEP_W-1:0] SCL_FIRST = STEP_W'(SMP_W - 1);

  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PCT  = 2'd2;
  // Unused code: the request changes nothing and returns the statistics.
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_ADD_PRE, OP_DIV, OP_MEAN, OP_MUL, OP_SPREAD,
    OP_BIN_ISSUE, OP_BIN_WRITE, OP_RD_ISSUE, OP_RD_USE, OP_SUM_INIT, OP_SUM_ISSUE,
    OP_SUM_ACC, OP_GOAL_MUL, OP_GOAL_ADD, OP_WALK_ISSUE, OP_WALK_USE, OP_SCALE,
    OP_PUBLISH
  } lsh_op_e;

  typedef struct packed {
    lsh_op_e op;
  } lsh_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic step_last;
    logic lim_zero;
    logic bin_over;
    logic walk_hit;
  } lsh_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sample_count;
    logic [TOT_W-1:0]  sample_total;
    logic [SMP_W-1:0]  sample_min;
    logic [SMP_W-1:0]  sample_max;
    logic [CNT_W-1:0]  running_mean;
    logic [SPR_W-1:0]  squared_spread;
    logic [CNT_W-1:0]  over_count;
    logic [CNT_W-1:0]  bin_value;
    logic [SMP_W-1:0]  percentile_value;
    logic              percentile_found;
  } lsh_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? x : x + 1'b1;
  endfunction

endpackage

// ===== rtl/lsh_if.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsh_req_if;
  logic                        valid;
  logic                        ready;
  logic [lsh_pkg::ACT_W-1:0]   action;
  logic [lsh_pkg::SMP_W-1:0]   sample;
  logic [lsh_pkg::IDX_W-1:0]   bin_index;
  logic [lsh_pkg::FRAC_W-1:0]  fraction;

  modport source (output valid, action, sample, bin_index, fraction, input ready);
  modport sink   (input valid, action, sample, bin_index, fraction, output ready);
endinterface

interface lsh_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lsh_pkg::CNT_W-1:0]   sample_count;
  logic [lsh_pkg::TOT_W-1:0]   sample_total;
  logic [lsh_pkg::SMP_W-1:0]   sample_min;
  logic [lsh_pkg::SMP_W-1:0]   sample_max;
  logic [lsh_pkg::CNT_W-1:0]   running_mean;
  logic [lsh_pkg::SPR_W-1:0]   squared_spread;
  logic [lsh_pkg::CNT_W-1:0]   over_count;
  logic [lsh_pkg::CNT_W-1:0]   bin_value;
  logic [lsh_pkg::SMP_W-1:0]   percentile_value;
  logic                        percentile_found;

  modport source (output valid, sample_count, sample_total, sample_min, sample_max,
                  running_mean, squared_spread, over_count, bin_value,
                  percentile_value, percentile_found, input ready);
  modport sink   (input valid, sample_count, sample_total, sample_min, sample_max,
                  running_mean, squared_spread, over_count, bin_value,
                  percentile_value, percentile_found, output ready);
endinterface

// ===== rtl/lsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram controller
// Sequences the datapath operations for each request and owns the handshakes.
// ----------------------------------------------------------------------------
module lsh_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [lsh_pkg::ACT_W-1:0] in_action_i,
  output logic                      in_ready_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  input  lsh_pkg::lsh_stat_t        stat_i,
  output lsh_pkg::lsh_cmd_t         cmd_o
);

  typedef enum logic [20:0] {
    S_CLEAR      = 21'h000001,
    S_IDLE       = 21'h000002,
    S_ADD_PRE    = 21'h000004,
    S_DIV_MEAN   = 21'h000008,
    S_MEAN       = 21'h000010,
    S_MUL        = 21'h000020,
    S_SPREAD     = 21'h000040,
    S_DIV_BIN    = 21'h000080,
    S_BIN_ISSUE  = 21'h000100,
    S_BIN_WRITE  = 21'h000200,
    S_RD_ISSUE   = 21'h000400,
    S_RD_USE     = 21'h000800,
    S_SUM_INIT   = 21'h001000,
    S_SUM_ISSUE  = 21'h002000,
    S_SUM_ACC    = 21'h004000,
    S_GOAL_MUL   = 21'h008000,
    S_GOAL_ADD   = 21'h010000,
    S_WALK_ISSUE = 21'h020000,
    S_WALK_USE   = 21'h040000,
    S_SCALE      = 21'h080000,
    S_DONE       = 21'h100000
  } lsh_state_e;

  lsh_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       publish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_ready_o && in_valid_i;
  assign publish     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = lsh_pkg::OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = lsh_pkg::OP_CLEAR;
        if (stat_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = lsh_pkg::OP_LOAD;
          if (in_action_i == lsh_pkg::ACT_ADD) begin
            state_d = S_ADD_PRE;
          end else if (in_action_i == lsh_pkg::ACT_READ) begin
            state_d = S_RD_ISSUE;
          end else if (in_action_i == lsh_pkg::ACT_PCT) begin
            state_d = S_SUM_INIT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ADD_PRE: begin
        cmd_o.op = lsh_pkg::OP_ADD_PRE;
        state_d  = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        cmd_o.op = lsh_pkg::OP_DIV;
        if (stat_i.step_last) state_d = S_MEAN;
      end
      S_MEAN: begin
        cmd_o.op = lsh_pkg::OP_MEAN;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = lsh_pkg::OP_MUL;
        if (stat_i.step_last) state_d = S_SPREAD;
      end
      S_SPREAD: begin
        cmd_o.op = lsh_pkg::OP_SPREAD;
        state_d  = stat_i.lim_zero ? S_DONE : S_DIV_BIN;
      end
      S_DIV_BIN: begin
        cmd_o.op = lsh_pkg::OP_DIV;
        if (stat_i.step_last) state_d = S_BIN_ISSUE;
      end
      S_BIN_ISSUE: begin
        cmd_o.op = lsh_pkg::OP_BIN_ISSUE;
        state_d  = stat_i.bin_over ? S_DONE : S_BIN_WRITE;
      end
      S_BIN_WRITE: begin
        cmd_o.op = lsh_pkg::OP_BIN_WRITE;
        state_d  = S_DONE;
      end
      S_RD_ISSUE: begin
        cmd_o.op = lsh_pkg::OP_RD_ISSUE;
        state_d  = S_RD_USE;
      end
      S_RD_USE: begin
        cmd_o.op = lsh_pkg::OP_RD_USE;
        state_d  = S_DONE;
      end
      S_SUM_INIT: begin
        cmd_o.op = lsh_pkg::OP_SUM_INIT;
        state_d  = S_SUM_ISSUE;
      end
      S_SUM_ISSUE: begin
        cmd_o.op = lsh_pkg::OP_SUM_ISSUE;
        state_d  = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.op = lsh_pkg::OP_SUM_ACC;
        state_d  = stat_i.idx_last ? S_GOAL_MUL : S_SUM_ISSUE;
      end
      S_GOAL_MUL: begin
        cmd_o.op = lsh_pkg::OP_GOAL_MUL;
        state_d  = S_GOAL_ADD;
      end
      S_GOAL_ADD: begin
        cmd_o.op = lsh_pkg::OP_GOAL_ADD;
        state_d  = S_WALK_ISSUE;
      end
      S_WALK_ISSUE: begin
        cmd_o.op = lsh_pkg::OP_WALK_ISSUE;
        state_d  = S_WALK_USE;
      end
      S_WALK_USE: begin
        cmd_o.op = lsh_pkg::OP_WALK_USE;
        if (stat_i.walk_hit) begin
          state_d = S_SCALE;
        end else if (stat_i.idx_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WALK_ISSUE;
        end
      end
      S_SCALE: begin
        cmd_o.op = lsh_pkg::OP_SCALE;
        if (stat_i.step_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (publish) begin
          cmd_o.op = lsh_pkg::OP_PUBLISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/lsh_datapath.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram datapath
// Statistics registers, shared divider, partial-product multiplier, bin
// memory, percentile walk and interpolation unit.
// ----------------------------------------------------------------------------
module lsh_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lsh_pkg::SMP_W-1:0]  cfg_wdata_i,
  input  logic [lsh_pkg::SMP_W-1:0]  sample_i,
  input  logic [lsh_pkg::IDX_W-1:0]  bin_index_i,
  input  logic [lsh_pkg::FRAC_W-1:0] fraction_i,
  input  lsh_pkg::lsh_cmd_t          cmd_i,
  output lsh_pkg::lsh_stat_t         stat_o,
  output lsh_pkg::lsh_rsp_t          rsp_o
);

  // Configuration and statistics state.
  logic [lsh_pkg::SMP_W-1:0]  limit_q;
  logic [lsh_pkg::CNT_W-1:0]  count_q, mean_q, over_q;
  logic [lsh_pkg::TOT_W-1:0]  total_q;
  logic [lsh_pkg::SPR_W-1:0]  spread_q;
  logic [lsh_pkg::SMP_W-1:0]  min_q, max_q;
  logic [lsh_pkg::BIN_W-1:0]  idx_q;
  logic [lsh_pkg::STEP_W-1:0] step_q;

  // Working registers.
  logic [lsh_pkg::SMP_W-1:0]  smp_q;
  logic [lsh_pkg::BIN_W-1:0]  bidx_q;
  logic                       idx_ok_q;
  logic [lsh_pkg::FRAC_W-1:0] frac_q;
  logic                       neg_q;
  logic [lsh_pkg::CNT_W-1:0]  ma_q, mb_q, rem_q, dvd_q, dvs_q;
  logic [lsh_pkg::CNT_W-1:0]  prod_q;
  logic [1:0]                 psh_q;
  logic [lsh_pkg::PROD_W-1:0] acc_q;
  logic [lsh_pkg::SUM_W-1:0]  sum_q, goal_q, ghi_q;
  logic [lsh_pkg::FRAC_W-1:0] glo_q;
  logic [lsh_pkg::D_W-1:0]    n_q, d_q, r_q;
  logic [lsh_pkg::SMP_W-1:0]  q_q;
  logic                       found_q;
  logic [lsh_pkg::CNT_W-1:0]  binv_q;
  lsh_pkg::lsh_rsp_t          rsp_q;

  // Bin memory.
  logic [lsh_pkg::CNT_W-1:0]  mem [lsh_pkg::BINS];
  logic [lsh_pkg::CNT_W-1:0]  rdata_q;
  logic [lsh_pkg::BIN_W-1:0]  raddr, waddr;
  logic [lsh_pkg::CNT_W-1:0]  wdata;
  logic                       we;

  logic [lsh_pkg::TOT_W:0]    tot_sum;
  logic [lsh_pkg::CNT_W-1:0]  cnt_new, v, dmag, mean_new, dmag2, bin_dvd;
  logic                       v_lt;
  logic [lsh_pkg::CNT_W:0]    trial;
  logic                       fits;
  logic [lsh_pkg::CNT_W-1:0]  rem_nx;
  logic [lsh_pkg::STEP_W-1:0] mj;
  logic [lsh_pkg::HALF_W-1:0] pa, pb;
  logic [1:0]                 psh_nx;
  logic [lsh_pkg::PROD_W-1:0] acc_add;
  logic [lsh_pkg::SPR_W-1:0]  spr_inc;
  logic [lsh_pkg::SPR_W:0]    spr_sum;
  logic [lsh_pkg::BIN_W-1:0]  idx_nx;
  logic [lsh_pkg::SUM_W-1:0]  ghi_nx, goal_nx;
  logic [2*lsh_pkg::FRAC_W-1:0] lop;
  logic                       sbit;
  logic [lsh_pkg::D_W+1:0]    r2, d1x, d2x;
  logic                       ge1, ge2;
  logic [lsh_pkg::D_W-1:0]    r_nx, n_nx, d_nx;
  logic [lsh_pkg::SMP_W-1:0]  q_nx;
  logic [1:0]                 kq;

  always_comb begin
    // Count, total and the Welford difference.
    tot_sum  = {1'b0, total_q} + (lsh_pkg::TOT_W + 1)'(smp_q);
    cnt_new  = lsh_pkg::sat_inc(count_q);
    v        = {smp_q, {lsh_pkg::FRAC_SH{1'b0}}};
    v_lt     = v < mean_q;
    dmag     = v_lt ? mean_q - v : v - mean_q;
    mean_new = neg_q ? mean_q - dvd_q : mean_q + dvd_q;
    dmag2    = neg_q ? mean_new - v : v - mean_new;
    bin_dvd  = lsh_pkg::CNT_W'(smp_q) * lsh_pkg::CNT_W'(lsh_pkg::BINS);

    // One restoring division step.
    trial  = {rem_q, dvd_q[lsh_pkg::CNT_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_nx = fits ? lsh_pkg::CNT_W'(trial - {1'b0, dvs_q}) : trial[lsh_pkg::CNT_W-1:0];

    // Partial products of the 48 by 48 spread product, one per cycle.
    mj     = lsh_pkg::MUL_FIRST - step_q;
    pa     = mj[1] ? ma_q[lsh_pkg::CNT_W-1:lsh_pkg::HALF_W] : ma_q[lsh_pkg::HALF_W-1:0];
    pb     = mj[0] ? mb_q[lsh_pkg::CNT_W-1:lsh_pkg::HALF_W] : mb_q[lsh_pkg::HALF_W-1:0];
    psh_nx = {1'b0, mj[1]} + {1'b0, mj[0]};
    case (psh_q)
      2'd0:    acc_add = lsh_pkg::PROD_W'(prod_q);
      2'd1:    acc_add = lsh_pkg::PROD_W'(prod_q) << lsh_pkg::HALF_W;
      2'd2:    acc_add = lsh_pkg::PROD_W'(prod_q) << (2 * lsh_pkg::HALF_W);
      default: acc_add = '0;
    endcase
    spr_inc = (|acc_q[lsh_pkg::PROD_W-1:lsh_pkg::FRAC_SH+lsh_pkg::SPR_W]) ? '1 :
              acc_q[lsh_pkg::FRAC_SH+lsh_pkg::SPR_W-1:lsh_pkg::FRAC_SH];
    spr_sum = {1'b0, spread_q} + {1'b0, spr_inc};

    // Bin walk and percentile goal.
    idx_nx  = (idx_q == lsh_pkg::BIN_W'(lsh_pkg::BINS - 1)) ? '0 : idx_q + 1'b1;
    ghi_nx  = lsh_pkg::SUM_W'(sum_q[lsh_pkg::SUM_W-1:lsh_pkg::FRAC_SH]) *
              lsh_pkg::SUM_W'(frac_q);
    lop     = (2*lsh_pkg::FRAC_W)'(sum_q[lsh_pkg::FRAC_SH-1:0]) *
              (2*lsh_pkg::FRAC_W)'(frac_q);
    goal_nx = ghi_q + lsh_pkg::SUM_W'(glo_q);
    n_nx    = lsh_pkg::D_W'(idx_q) * lsh_pkg::D_W'(rdata_q) + lsh_pkg::D_W'(goal_q);
    d_nx    = lsh_pkg::D_W'(rdata_q) * lsh_pkg::D_W'(lsh_pkg::BINS);

    // One bit of floor(n * limit / d); the remainder can pass d at most twice.
    sbit = limit_q[step_q[lsh_pkg::SBIT_W-1:0]];
    r2   = {1'b0, r_q, 1'b0} + (sbit ? (lsh_pkg::D_W + 2)'(n_q) : '0);
    d1x  = {2'b0, d_q};
    d2x  = {1'b0, d_q, 1'b0};
    ge2  = r2 >= d2x;
    ge1  = r2 >= d1x;
    if (ge2) begin
      r_nx = lsh_pkg::D_W'(r2 - d2x);
      kq   = 2'd2;
    end else if (ge1) begin
      r_nx = lsh_pkg::D_W'(r2 - d1x);
      kq   = 2'd1;
    end else begin
      r_nx = r2[lsh_pkg::D_W-1:0];
      kq   = 2'd0;
    end
    q_nx = {q_q[lsh_pkg::SMP_W-2:0], 1'b0} + lsh_pkg::SMP_W'(kq);

    // Memory port selection.
    if (cmd_i.op == lsh_pkg::OP_BIN_ISSUE) begin
      raddr = dvd_q[lsh_pkg::BIN_W-1:0];
    end else if (cmd_i.op == lsh_pkg::OP_RD_ISSUE) begin
      raddr = bidx_q;
    end else begin
      raddr = idx_q;
    end
    we    = (cmd_i.op == lsh_pkg::OP_CLEAR) || (cmd_i.op == lsh_pkg::OP_BIN_WRITE);
    waddr = (cmd_i.op == lsh_pkg::OP_CLEAR) ? idx_q : dvd_q[lsh_pkg::BIN_W-1:0];
    wdata = (cmd_i.op == lsh_pkg::OP_CLEAR) ? '0 : lsh_pkg::sat_inc(rdata_q);
  end

  assign stat_o.idx_last  = (idx_q == lsh_pkg::BIN_W'(lsh_pkg::BINS - 1));
  assign stat_o.step_last = (step_q == '0);
  assign stat_o.lim_zero  = (limit_q == '0);
  assign stat_o.bin_over  = (dvd_q >= lsh_pkg::CNT_W'(lsh_pkg::BINS));
  assign stat_o.walk_hit  = lsh_pkg::SUM_W'(rdata_q) > goal_q;
  assign rsp_o            = rsp_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= '0;
      count_q  <= '0;
      total_q  <= '0;
      min_q    <= '0;
      max_q    <= '0;
      mean_q   <= '0;
      spread_q <= '0;
      over_q   <= '0;
      idx_q    <= '0;
      step_q   <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      unique case (cmd_i.op)
        lsh_pkg::OP_CLEAR: idx_q <= idx_nx;
        lsh_pkg::OP_ADD_PRE: begin
          total_q <= tot_sum[lsh_pkg::TOT_W] ? '1 : tot_sum[lsh_pkg::TOT_W-1:0];
          if (count_q == '0) begin
            min_q <= smp_q;
            max_q <= smp_q;
          end else begin
            if (smp_q < min_q) min_q <= smp_q;
            if (smp_q > max_q) max_q <= smp_q;
          end
          count_q <= cnt_new;
          step_q  <= lsh_pkg::DIV_FIRST;
        end
        lsh_pkg::OP_DIV, lsh_pkg::OP_MUL, lsh_pkg::OP_SCALE: step_q <= step_q - 1'b1;
        lsh_pkg::OP_MEAN: begin
          mean_q <= mean_new;
          step_q <= lsh_pkg::MUL_FIRST;
        end
        lsh_pkg::OP_SPREAD: begin
          spread_q <= spr_sum[lsh_pkg::SPR_W] ? '1 : spr_sum[lsh_pkg::SPR_W-1:0];
          step_q   <= lsh_pkg::DIV_FIRST;
        end
        lsh_pkg::OP_BIN_ISSUE: begin
          if (stat_o.bin_over) over_q <= lsh_pkg::sat_inc(over_q);
        end
        lsh_pkg::OP_SUM_INIT, lsh_pkg::OP_GOAL_ADD: idx_q <= '0;
        lsh_pkg::OP_SUM_ACC: idx_q <= idx_nx;
        lsh_pkg::OP_WALK_USE: begin
          idx_q <= idx_nx;
          if (stat_o.walk_hit) step_q <= lsh_pkg::SCL_FIRST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      lsh_pkg::OP_LOAD: begin
        smp_q    <= sample_i;
        bidx_q   <= lsh_pkg::BIN_W'(bin_index_i);
        idx_ok_q <= 32'(bin_index_i) < lsh_pkg::BINS;
        frac_q   <= fraction_i;
        binv_q   <= '0;
        q_q      <= '0;
        found_q  <= 1'b0;
      end
      lsh_pkg::OP_ADD_PRE: begin
        neg_q <= v_lt;
        ma_q  <= dmag;
        rem_q <= '0;
        dvd_q <= dmag;
        dvs_q <= cnt_new;
      end
      lsh_pkg::OP_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[lsh_pkg::CNT_W-2:0], fits};
      end
      lsh_pkg::OP_MEAN: begin
        mb_q  <= dmag2;
        acc_q <= '0;
      end
      lsh_pkg::OP_MUL: begin
        if (mj < lsh_pkg::MUL_FIRST) begin
          prod_q <= pa * pb;
          psh_q  <= psh_nx;
        end
        if (mj != '0) acc_q <= acc_q + acc_add;
      end
      lsh_pkg::OP_SPREAD: begin
        rem_q <= '0;
        dvd_q <= bin_dvd;
        dvs_q <= lsh_pkg::CNT_W'(limit_q);
      end
      lsh_pkg::OP_RD_USE: binv_q <= idx_ok_q ? rdata_q : '0;
      lsh_pkg::OP_SUM_INIT: sum_q <= lsh_pkg::SUM_W'(over_q);
      lsh_pkg::OP_SUM_ACC: sum_q <= sum_q + lsh_pkg::SUM_W'(rdata_q);
      lsh_pkg::OP_GOAL_MUL: begin
        ghi_q <= ghi_nx;
        glo_q <= lop[2*lsh_pkg::FRAC_W-1:lsh_pkg::FRAC_W];
      end
      lsh_pkg::OP_GOAL_ADD: goal_q <= goal_nx;
      lsh_pkg::OP_WALK_USE: begin
        if (stat_o.walk_hit) begin
          n_q     <= n_nx;
          d_q     <= d_nx;
          r_q     <= '0;
          q_q     <= '0;
          found_q <= 1'b1;
        end else begin
          goal_q <= goal_q - lsh_pkg::SUM_W'(rdata_q);
        end
      end
      lsh_pkg::OP_SCALE: begin
        r_q <= r_nx;
        q_q <= q_nx;
      end
      lsh_pkg::OP_PUBLISH: begin
        rsp_q.sample_count     <= count_q;
        rsp_q.sample_total     <= total_q;
        rsp_q.sample_min       <= min_q;
        rsp_q.sample_max       <= max_q;
        rsp_q.running_mean     <= mean_q;
        rsp_q.squared_spread   <= spread_q;
        rsp_q.over_count       <= over_q;
        rsp_q.bin_value        <= binv_q;
        rsp_q.percentile_value <= q_q;
        rsp_q.percentile_found <= found_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/latency_stats_histogram.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram
// Running latency statistics, a binned histogram and percentile lookup.
// ----------------------------------------------------------------------------
//
// Channel    Dir   Handshake            Contents
// req        in    valid/ready          action, sample, bin_index, fraction
// rsp        out   valid/ready          statistics, bin_value, percentile
// cfg        in    cfg_we_i (no wait)   hist_limit
//
// After reset a clearing pass zeroes the bin memory, one bin per cycle, over
// all BINS (1024) bins, during which no request is taken.
// An add request runs two 48-step divisions in the shared restoring divider,
// the second only for a nonzero limit, plus the four partial products of the spread.
// A read-bin request waits on the registered memory read.
// A percentile request runs a summing pass over every bin, a walk over the
// bins until one passes the goal, and a 32-step divide to interpolate a hit.
// The response sits in an output register, so a new request is taken while
// the previous response is still waiting for rsp.ready.
module latency_stats_histogram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lsh_pkg::SMP_W-1:0] cfg_wdata_i,
  lsh_req_if.sink                   req,
  lsh_rsp_if.source                 rsp
);

  lsh_pkg::lsh_cmd_t  cmd;
  lsh_pkg::lsh_stat_t stat;
  lsh_pkg::lsh_rsp_t  res;

  // The controller owns both handshakes and steps the datapath one operation
  // per cycle, pausing while the previous response waits for rsp.ready.
  lsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_action_i (req.action),
    .in_ready_o  (req.ready),
    .out_ready_i (rsp.ready),
    .out_valid_o (rsp.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds all statistics, the bin memory and the arithmetic.
  lsh_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (req.sample),
    .bin_index_i (req.bin_index),
    .fraction_i  (req.fraction),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (res)
  );

  assign rsp.sample_count     = res.sample_count;
  assign rsp.sample_total     = res.sample_total;
  assign rsp.sample_min       = res.sample_min;
  assign rsp.sample_max       = res.sample_max;
  assign rsp.running_mean     = res.running_mean;
  assign rsp.squared_spread   = res.squared_spread;
  assign rsp.over_count       = res.over_count;
  assign rsp.bin_value        = res.bin_value;
  assign rsp.percentile_value = res.percentile_value;
  assign rsp.percentile_found = res.percentile_found;

`ifndef SYNTH
  // A taken request always leaves the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while the previous one was in progress");

  // Publishing a result always presents a response.
  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == lsh_pkg::OP_PUBLISH |=> rsp.valid)
    else $error("published response not presented");

  // No request is taken while the bin memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == lsh_pkg::OP_CLEAR |-> !req.ready)
    else $error("request ready during the clearing pass");
`endif

endmodule

// ===== tb/lsh_checker.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram checker
// Watches the request and response channels, predicts every response from
// its own copy of the statistics and histogram, and counts mismatches.
// ----------------------------------------------------------------------------
module lsh_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lsh_pkg::SMP_W-1:0] cfg_wdata_i,
  lsh_req_if.sink                   req_mon,
  lsh_rsp_if.sink                   rsp_mon,
  output int unsigned               err_cnt_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] U64_MAX = '1;
  localparam logic [47:0] C48_MAX = '1;

  logic [31:0] limit_q;
  logic [47:0] count_q, mean_q, over_q;
  logic [63:0] total_q, spread_q;
  logic [31:0] min_q, max_q;
  logic [47:0] bins_q [lsh_pkg::BINS];
  lsh_pkg::lsh_rsp_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [47:0] inc_sat(logic [47:0] x);
    return (x == C48_MAX) ? x : x + 48'd1;
  endfunction

  task automatic record_sample(logic [31:0] x);
    logic [63:0]  v, dmag, dmag2, step, bin;
    logic [127:0] prod;
    logic         neg;
    v = {16'd0, x, 16'd0};
    total_q = (total_q + 64'(x) < total_q) ? U64_MAX : total_q + 64'(x);
    if (count_q == 0) begin
      min_q = x;
      max_q = x;
    end else begin
      if (x < min_q) min_q = x;
      if (x > max_q) max_q = x;
    end
    count_q = inc_sat(count_q);
    neg = v < {16'd0, mean_q};
    dmag = neg ? {16'd0, mean_q} - v : v - {16'd0, mean_q};
    step = dmag / {16'd0, count_q};
    mean_q = neg ? mean_q - step[47:0] : mean_q + step[47:0];
    dmag2 = neg ? {16'd0, mean_q} - v : v - {16'd0, mean_q};
    prod = (128'(dmag) * 128'(dmag2)) >> 16;
    step = (prod[127:64] != 0) ? U64_MAX : prod[63:0];
    spread_q = (spread_q + step < spread_q) ? U64_MAX : spread_q + step;
    if (limit_q != 0) begin
      bin = (64'(x) * 64'(lsh_pkg::BINS)) / 64'(limit_q);
      if (bin < 64'(lsh_pkg::BINS)) begin
        bins_q[bin[lsh_pkg::BIN_W-1:0]] = inc_sat(bins_q[bin[lsh_pkg::BIN_W-1:0]]);
      end else begin
        over_q = inc_sat(over_q);
      end
    end
  endtask

  // Walks the histogram for the bin holding the requested fraction.
  function automatic logic percentile_lookup(logic [15:0] frac, output logic [31:0] val);
    logic [63:0]  sum, goal, c;
    logic [127:0] num;
    sum = 64'(over_q);
    for (int i = 0; i < lsh_pkg::BINS; i++) sum += 64'(bins_q[lsh_pkg::BIN_W'(i)]);
    goal = (sum >> 16) * 64'(frac) + (((sum & 64'hFFFF) * 64'(frac)) >> 16);
    val = '0;
    for (int i = 0; i < lsh_pkg::BINS; i++) begin
      c = 64'(bins_q[lsh_pkg::BIN_W'(i)]);
      if (c > goal) begin
        num = (128'(64'(i) * c + goal) * 128'(limit_q)) /
              (128'(c) * 128'(lsh_pkg::BINS));
        val = num[31:0];
        return 1'b1;
      end
      goal -= c;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lsh_pkg::lsh_rsp_t exp_r, got;
    if (!rst_ni) begin
      limit_q = '0; count_q = '0; total_q = '0; min_q = '0; max_q = '0;
      mean_q = '0; spread_q = '0; over_q = '0; err_cnt_o <= 0;
      for (int i = 0; i < lsh_pkg::BINS; i++) bins_q[lsh_pkg::BIN_W'(i)] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (req_mon.valid && req_mon.ready) begin
        exp_r = '0;
        case (req_mon.action)
          lsh_pkg::ACT_ADD:  record_sample(req_mon.sample);
          lsh_pkg::ACT_READ: exp_r.bin_value = bins_q[req_mon.bin_index];
          lsh_pkg::ACT_PCT:  exp_r.percentile_found =
                      percentile_lookup(req_mon.fraction, exp_r.percentile_value);
          default: ;
        endcase
        exp_r.sample_count = count_q;  exp_r.sample_total = total_q;
        exp_r.sample_min = min_q;      exp_r.sample_max = max_q;
        exp_r.running_mean = mean_q;   exp_r.squared_spread = spread_q;
        exp_r.over_count = over_q;
        expected_q.push_back(exp_r);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.sample_count, rsp_mon.sample_total, rsp_mon.sample_min,
                rsp_mon.sample_max, rsp_mon.running_mean, rsp_mon.squared_spread,
                rsp_mon.over_count, rsp_mon.bin_value, rsp_mon.percentile_value,
                rsp_mon.percentile_found};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, got);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Latency statistics histogram testbench
// Drives directed and random requests and histogram limits, with bursty
// requests and a stalling response side, and reports the checker verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lsh_pkg::SMP_W-1:0] cfg_wdata_i = '0;
  int unsigned err_cnt, pending;
  // While set, the response side holds off completely so the block backs up.
  logic hold_rsp = 1'b0;

  lsh_req_if req ();
  lsh_rsp_if rsp ();

  always #4 clk_i = ~clk_i;

  latency_stats_histogram uut (.clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req, .rsp);

  lsh_checker chk (.clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_mon(req),
                   .rsp_mon(rsp), .err_cnt_o(err_cnt), .pending_o(pending));

  initial begin
    req.valid = 1'b0; req.action = lsh_pkg::ACT_ADD; req.sample = '0;
    req.bin_index = '0; req.fraction = '0; rsp.ready = 1'b0;
  end

  // The response side stalls on a pattern of its own: calm stretches, busy ones.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (mode == 0) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) >= mode);
    end
  end

  // Offers one request and holds it until the block takes it. Before it,
  // sometimes a random gap, so bursts alternate with pauses.
  task automatic send_request(logic [lsh_pkg::ACT_W-1:0] act, logic [31:0] smp,
                              logic [9:0] idx, logic [15:0] frac);
    if ($urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    req.valid <= 1'b1; req.action <= act; req.sample <= smp;
    req.bin_index <= idx; req.fraction <= frac;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic idle_until_drained;
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4200) @(posedge clk_i);
  endtask

  // Only written while the block is idle.
  task automatic write_limit(logic [31:0] lim);
    cfg_we_i <= 1'b1; cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random sample biased toward the covered range, with small and huge extremes.
  function automatic logic [31:0] pick_sample(logic [31:0] lim);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return (lim == 0) ? $urandom_range(0, 4000) : $urandom_range(0, lim);
    endcase
  endfunction

  task automatic random_phase(logic [31:0] lim, int n);
    int a;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(0, 19);
      if (a < 13) begin
        send_request(lsh_pkg::ACT_ADD, pick_sample(lim), 10'($urandom), 16'($urandom));
      end else if (a < 17) begin
        send_request(lsh_pkg::ACT_READ, $urandom, 10'($urandom), 16'($urandom));
      end else if (a < 19) begin
        send_request(lsh_pkg::ACT_PCT, $urandom, 10'($urandom), 16'($urandom));
      end else begin
        send_request(lsh_pkg::ACT_NONE, $urandom, 10'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] lims [4];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an empty histogram and a disabled limit first.
    send_request(lsh_pkg::ACT_PCT, '0, '0, 16'h8000);
    send_request(lsh_pkg::ACT_READ, '0, '0, '0);
    send_request(lsh_pkg::ACT_NONE, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF);
    send_request(lsh_pkg::ACT_ADD, 32'd0, '0, '0);
    send_request(lsh_pkg::ACT_ADD, 32'hFFFF_FFFF, '0, '0);
    idle_until_drained();
    write_limit(32'd1000);
    send_request(lsh_pkg::ACT_ADD, 32'd0, '0, '0);
    send_request(lsh_pkg::ACT_ADD, 32'd999, '0, '0);
    send_request(lsh_pkg::ACT_ADD, 32'd1000, '0, '0);
    send_request(lsh_pkg::ACT_ADD, 32'd500, '0, '0);
    send_request(lsh_pkg::ACT_ADD, 32'hFFFF_FFFF, '0, '0);
    send_request(lsh_pkg::ACT_READ, '0, 10'd0, '0);
    send_request(lsh_pkg::ACT_READ, '0, 10'h3FF, '0);
    send_request(lsh_pkg::ACT_READ, '0, 10'd512, '0);
    send_request(lsh_pkg::ACT_PCT, '0, '0, 16'h0000);
    send_request(lsh_pkg::ACT_PCT, '0, '0, 16'h8000);
    send_request(lsh_pkg::ACT_PCT, '0, '0, 16'hFFFF);
    idle_until_drained();

    // A zero limit during a query leaves a found value at zero.
    write_limit(32'd0);
    send_request(lsh_pkg::ACT_PCT, '0, '0, 16'h1000);
    send_request(lsh_pkg::ACT_ADD, 32'd77, '0, '0);
    idle_until_drained();

    // Back-pressure: hold the response side while requests keep coming.
    write_limit(32'd4096);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      random_phase(32'd4096, 12);
    join
    idle_until_drained();

    lims = '{32'd1, 32'd64, 32'hFFFF_FFFF, 32'd100000};
    foreach (lims[k]) begin
      write_limit(lims[k]);
      random_phase(lims[k], 90);
      idle_until_drained();
    end

    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #150ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/lsh_pkg.sv
rtl/lsh_if.sv
rtl/lsh_ctrl.sv
rtl/lsh_datapath.sv
rtl/latency_stats_histogram.sv
tb/lsh_checker.sv
tb/testbench.sv
